### design/assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### design/deq_pkg.sv
`default_nettype none

package deq_pkg;

    localparam int MODE_W = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 11;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PEEK_BACK  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SIZE       = 3'd6;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_DATA  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_dp_cmd;

endpackage

`default_nettype wire

### design/deq_if.sv
`default_nettype none

interface deq_in_if import deq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, mode, push_value, input ready);
    modport sink   (input valid, mode, push_value, output ready);
endinterface

interface deq_out_if import deq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data_out;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, status, data_out, occupancy, input ready);
    modport sink   (input valid, status, data_out, occupancy, output ready);
endinterface

`default_nettype wire

### design/deq_ctrl.sv
`default_nettype none

module deq_ctrl import deq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_dp_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_RESP);
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec    = (r_state == S_EXEC);

endmodule

`default_nettype wire

### design/deq_dp.sv
`default_nettype none
`include "assert_macros.svh"

module deq_dp import deq_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    input  wire logic [MODE_W-1:0]        i_mode,
    input  wire logic signed [DATA_W-1:0] i_push_value,
    output logic [STAT_W-1:0]             o_status,
    output logic signed [DATA_W-1:0]      o_data_out,
    output logic [OCC_W-1:0]              o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    logic [DATA_W-1:0] r_mem [DEPTH];

    logic [MODE_W-1:0] r_mode;
    logic [DATA_W-1:0] r_value;
    logic [AW-1:0]     r_back;
    logic [CW-1:0]     r_count;
    logic [STAT_W-1:0] r_status;
    logic [DATA_W-1:0] r_rd_data;

    logic [AW-1:0]     n_back;
    logic [CW-1:0]     n_count;
    logic [STAT_W-1:0] n_status;

    logic              empty;
    logic              full;
    logic [AW-1:0]     back_dec;
    logic [AW-1:0]     back_inc;
    logic [SW-1:0]     s_push;
    logic [SW-1:0]     s_front;
    logic [AW-1:0]     push_idx;
    logic [AW-1:0]     front_idx;
    logic              we;
    logic              re;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [CW+OCC_W-1:0] occ_ext;

    assign empty    = (r_count == '0);
    assign full     = (r_count == CW'(DEPTH));
    assign back_dec = (r_back == '0) ? AW'(DEPTH - 1) : r_back - 1'b1;
    assign back_inc = (r_back == AW'(DEPTH - 1)) ? '0 : r_back + 1'b1;

    // both sums stay below twice the depth, so one subtract wraps them
    assign s_push    = {1'b0, r_back} + SW'(r_count);
    assign s_front   = s_push - 1'b1;
    assign push_idx  = (s_push >= SW'(DEPTH)) ? AW'(s_push - SW'(DEPTH)) : AW'(s_push);
    assign front_idx = (s_front >= SW'(DEPTH)) ? AW'(s_front - SW'(DEPTH)) : AW'(s_front);

    always_comb begin
        n_back   = r_back;
        n_count  = r_count;
        n_status = ST_OK;
        we       = 1'b0;
        re       = 1'b0;
        waddr    = push_idx;
        raddr    = r_back;
        case (r_mode)
            MODE_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_PUSH_BACK: begin
                waddr = back_dec;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    we      = 1'b1;
                    n_back  = back_dec;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_POP_FRONT, MODE_PEEK_FRONT: begin
                raddr = front_idx;
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    re       = 1'b1;
                    n_status = ST_DATA;
                    if (r_mode == MODE_POP_FRONT) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            MODE_POP_BACK, MODE_PEEK_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    re       = 1'b1;
                    n_status = ST_DATA;
                    if (r_mode == MODE_POP_BACK) begin
                        n_back  = back_inc;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            MODE_SIZE: begin
                n_status = ST_OK;
            end
            MODE_CLEAR: begin
                n_back  = '0;
                n_count = '0;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_value <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_back  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && we) begin
            r_mem[waddr] <= r_value;
        end
        if (i_cmd.exec && re) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    assign occ_ext     = {{OCC_W{1'b0}}, r_count};
    assign o_occupancy = occ_ext[OCC_W-1:0];
    assign o_status    = r_status;
    assign o_data_out  = (r_status == ST_DATA) ? r_rd_data : '0;

    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CW'(DEPTH), "count above depth")
    `ASSERT_NEVER(a_back_bound, i_clk, i_rst_n, {1'b0, r_back} >= SW'(DEPTH), "back ptr out of range")
    `ASSERT_CLK(a_push_count, i_clk, i_rst_n, (i_cmd.exec && we) |=> (r_count == $past(r_count) + CW'(1)), "push count slip")

endmodule

`default_nettype wire

### design/double_ended_queue_core.sv
`default_nettype none

// Bounded double-ended queue of signed 32-bit values in a circular store of
// DEPTH entries. Each request item carries one operation (push/pop/peek at
// either end, size, clear) and yields exactly one response item with status,
// data and occupancy after the operation. Items are handled one at a time:
// a request is accepted in idle, the next cycle does the pointer update and
// at most one store access (one write or one registered read), and the
// response is then held in the output register until taken; no new request
// is accepted before that. The store needs no clearing pass after reset;
// only held entries are ever read.
module double_ended_queue_core import deq_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    deq_in_if.sink     i_req,
    deq_out_if.source  o_rsp
);

    t_dp_cmd cmd;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_mode       (i_req.mode),
        .i_push_value (i_req.push_value),
        .o_status     (o_rsp.status),
        .o_data_out   (o_rsp.data_out),
        .o_occupancy  (o_rsp.occupancy)
    );

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps

module testbench import deq_pkg::*; ();

    localparam int DEPTH        = 1024;
    localparam int PTR_W        = $clog2(DEPTH);
    localparam int DIR_N        = 25;
    localparam int PRESS_ITEMS  = 40;
    localparam int RAND_ITEMS   = 730;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] data;
        logic [OCC_W-1:0]         occ;
    } deq_result_t;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
        logic                     typed;
        deq_result_t              want;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;

    deq_in_if  req_ch();
    deq_out_if rsp_ch();

    double_ended_queue_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // shadow deque
    logic signed [DATA_W-1:0] slot_mem [DEPTH];
    logic [PTR_W-1:0]         back_ptr;
    logic [OCC_W-1:0]         held_cnt;

    // expected results in order, indexed by a running item number
    deq_result_t exp_tab [int unsigned];
    int unsigned exp_wr;
    int unsigned exp_rd;

    int unsigned errors;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned full_seen;
    int unsigned empty_seen;
    int unsigned data_seen;
    int unsigned peak_occ;
    int unsigned burst_left;
    bit          gaps_on;
    bit          hold_off_req;

    stim_row_t directed_rows [DIR_N] = '{
        '{MODE_PEEK_FRONT, 32'h0,        1'b1, '{ST_EMPTY, 32'h0,        11'd0}},
        '{MODE_POP_BACK,   32'hffffffff, 1'b1, '{ST_EMPTY, 32'h0,        11'd0}},
        '{MODE_POP_FRONT,  32'h0,        1'b1, '{ST_EMPTY, 32'h0,        11'd0}},
        '{MODE_PEEK_BACK,  32'h0,        1'b1, '{ST_EMPTY, 32'h0,        11'd0}},
        '{MODE_SIZE,       32'h0,        1'b1, '{ST_OK,    32'h0,        11'd0}},
        '{MODE_PUSH_FRONT, 32'h7fffffff, 1'b1, '{ST_OK,    32'h0,        11'd1}},
        '{MODE_PUSH_BACK,  32'h80000000, 1'b1, '{ST_OK,    32'h0,        11'd2}},
        '{MODE_PEEK_FRONT, 32'h0,        1'b1, '{ST_DATA,  32'h7fffffff, 11'd2}},
        '{MODE_PEEK_BACK,  32'h0,        1'b1, '{ST_DATA,  32'h80000000, 11'd2}},
        '{MODE_PUSH_FRONT, 32'hffffffff, 1'b1, '{ST_OK,    32'h0,        11'd3}},
        '{MODE_PUSH_BACK,  32'h0,        1'b1, '{ST_OK,    32'h0,        11'd4}},
        '{MODE_SIZE,       32'h7fffffff, 1'b1, '{ST_OK,    32'h0,        11'd4}},
        '{MODE_POP_FRONT,  32'h0,        1'b1, '{ST_DATA,  32'hffffffff, 11'd3}},
        '{MODE_POP_BACK,   32'h0,        1'b1, '{ST_DATA,  32'h0,        11'd2}},
        '{MODE_POP_FRONT,  32'h0,        1'b1, '{ST_DATA,  32'h7fffffff, 11'd1}},
        '{MODE_POP_FRONT,  32'h0,        1'b1, '{ST_DATA,  32'h80000000, 11'd0}},
        '{MODE_POP_BACK,   32'h0,        1'b1, '{ST_EMPTY, 32'h0,        11'd0}},
        '{MODE_PUSH_BACK,  32'h5555aaaa, 1'b1, '{ST_OK,    32'h0,        11'd1}},
        '{MODE_PUSH_BACK,  32'haaaa5555, 1'b1, '{ST_OK,    32'h0,        11'd2}},
        '{MODE_CLEAR,      32'h12345678, 1'b1, '{ST_OK,    32'h0,        11'd0}},
        '{MODE_PEEK_BACK,  32'h0,        1'b1, '{ST_EMPTY, 32'h0,        11'd0}},
        '{MODE_PUSH_FRONT, 32'h1,        1'b1, '{ST_OK,    32'h0,        11'd1}},
        '{MODE_POP_BACK,   32'h0,        1'b1, '{ST_DATA,  32'h1,        11'd0}},
        '{MODE_PUSH_BACK,  32'h80000001, 1'b0, '{ST_OK,    32'h0,        11'd0}},
        '{MODE_CLEAR,      32'h0,        1'b1, '{ST_OK,    32'h0,        11'd0}}
    };

    function automatic deq_result_t deque_apply(input logic [MODE_W-1:0] op,
                                                input logic signed [DATA_W-1:0] value);
        deq_result_t      res;
        logic [PTR_W-1:0] idx;
        res = '{ST_OK, '0, '0};
        case (op)
            MODE_PUSH_FRONT: begin
                if (held_cnt == OCC_W'(DEPTH)) begin
                    res.status = ST_FULL;
                end else begin
                    idx = back_ptr + held_cnt[PTR_W-1:0];
                    slot_mem[idx] = value;
                    held_cnt = held_cnt + 1'b1;
                end
            end
            MODE_PUSH_BACK: begin
                if (held_cnt == OCC_W'(DEPTH)) begin
                    res.status = ST_FULL;
                end else begin
                    back_ptr = back_ptr - 1'b1;
                    slot_mem[back_ptr] = value;
                    held_cnt = held_cnt + 1'b1;
                end
            end
            MODE_POP_FRONT, MODE_PEEK_FRONT: begin
                if (held_cnt == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    idx = back_ptr + held_cnt[PTR_W-1:0] - 1'b1;
                    res.status = ST_DATA;
                    res.data = slot_mem[idx];
                    if (op == MODE_POP_FRONT) held_cnt = held_cnt - 1'b1;
                end
            end
            MODE_POP_BACK, MODE_PEEK_BACK: begin
                if (held_cnt == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.status = ST_DATA;
                    res.data = slot_mem[back_ptr];
                    if (op == MODE_POP_BACK) begin
                        back_ptr = back_ptr + 1'b1;
                        held_cnt = held_cnt - 1'b1;
                    end
                end
            end
            MODE_SIZE: begin
            end
            default: begin
                held_cnt = '0;
                back_ptr = '0;
            end
        endcase
        res.occ = held_cnt;
        return res;
    endfunction

    function automatic logic [MODE_W-1:0] pick_op(input int unsigned push_pct);
        int unsigned sel;
        if ($urandom_range(99) < push_pct) begin
            return $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        end
        sel = $urandom_range(63);
        if (sel == 0) return MODE_CLEAR;
        if (sel < 4) return MODE_SIZE;
        case (sel % 4)
            0: return MODE_POP_FRONT;
            1: return MODE_POP_BACK;
            2: return MODE_PEEK_FRONT;
            default: return MODE_PEEK_BACK;
        endcase
    endfunction

    task automatic send_op(input logic [MODE_W-1:0] op, input logic signed [DATA_W-1:0] value,
                           input logic typed, input deq_result_t want);
        deq_result_t predicted;
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= op;
        req_ch.push_value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = deque_apply(op, value);
        exp_tab[exp_wr] = typed ? want : predicted;
        exp_wr++;
        items_sent++;
        if (gaps_on) begin
            if (burst_left == 0) begin
                req_ch.valid      <= 1'b0;
                req_ch.mode       <= MODE_W'($urandom);
                req_ch.push_value <= $urandom;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = $urandom_range(1, 20);
            end else begin
                burst_left--;
            end
        end
    endtask

    initial begin : request_feed
        deq_result_t none;
        int unsigned push_pct;
        none = '0;
        exp_wr = 0;
        exp_rd = 0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        full_seen = 0;
        empty_seen = 0;
        data_seen = 0;
        peak_occ = 0;
        burst_left = 4;
        gaps_on = 1'b1;
        hold_off_req = 1'b0;
        back_ptr = '0;
        held_cnt = '0;
        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.mode <= '0;
        req_ch.push_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            send_op(directed_rows[i].mode, directed_rows[i].value,
                    directed_rows[i].typed, directed_rows[i].want);
        end

        // push back to back while the response side holds off
        gaps_on = 1'b0;
        hold_off_req = 1'b1;
        for (int i = 0; i < PRESS_ITEMS; i++) begin
            send_op($urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, $urandom, 1'b0, none);
        end
        send_op(MODE_PEEK_FRONT, $urandom, 1'b0, none);
        send_op(MODE_PEEK_BACK, $urandom, 1'b0, none);
        send_op(MODE_SIZE, $urandom, 1'b0, none);

        push_pct = 30;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 100 == 0) begin
                push_pct = $urandom_range(20, 80);
                gaps_on = ($urandom_range(3) != 0);
            end
            send_op(pick_op(push_pct), $urandom, 1'b0, none);
        end

        req_ch.valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d items sent, %0d results checked: %0d data, %0d empty, %0d full",
                 items_sent, results_seen, data_seen, empty_seen, full_seen);
        $display("peak occupancy %0d of %0d, %0d mismatches", peak_occ, DEPTH, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : response_drain
        int unsigned stall_cyc;
        int unsigned style;
        stall_cyc = 0;
        style = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (stall_cyc % 128 == 0) style = $urandom_range(3);
            stall_cyc++;
            case (style)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= $urandom_range(1);
                2: rsp_ch.ready <= (stall_cyc % 4 == 0);
                default: rsp_ch.ready <= ($urandom_range(7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        deq_result_t want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (rsp_ch.status == ST_FULL) full_seen++;
            if (rsp_ch.status == ST_EMPTY) empty_seen++;
            if (rsp_ch.status == ST_DATA) data_seen++;
            if (rsp_ch.occupancy > peak_occ) peak_occ = 32'(rsp_ch.occupancy);
            if (exp_wr == exp_rd) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h %h %0d", $time,
                         rsp_ch.status, rsp_ch.data_out, rsp_ch.occupancy);
            end else begin
                want = exp_tab[exp_rd];
                exp_tab.delete(exp_rd);
                exp_rd++;
                if (rsp_ch.status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d got %0d", $time,
                             want.status, rsp_ch.status);
                end
                if (rsp_ch.data_out !== want.data) begin
                    errors++;
                    $display("%0t: data_out expected %h got %h", $time,
                             want.data, rsp_ch.data_out);
                end
                if (rsp_ch.occupancy !== want.occ) begin
                    errors++;
                    $display("%0t: occupancy expected %0d got %0d", $time,
                             want.occ, rsp_ch.occupancy);
                end
            end
        end
    end

    // no progress on either channel for too long
    always @(posedge i_clk) begin
        int unsigned idle_cyc;
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cyc = 0;
        end else begin
            idle_cyc++;
            if (idle_cyc >= IDLE_LIMIT) begin
                $display("%0t: timeout, %0d results outstanding", $time, exp_wr - exp_rd);
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
